>>> rtl/core/mvne_pkg.sv
`timescale 1ns / 1ps

package mvne_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int POS_BITS_DEF     = 16;
  localparam int ACC_BITS_DEF     = 44;

  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic [15:0]        THRESH_RST = 16'd7;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  localparam logic REG_FLAT   = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic                used_default;
    logic signed [15:0]  normal_z;
    logic signed [15:0]  normal_y;
    logic signed [15:0]  normal_x;
  } res_t;

  localparam res_t RES_DEFAULT = '{
    used_default: 1'b1,
    normal_z:     ONE_Q14,
    normal_y:     16'sd0,
    normal_x:     16'sd0
  };

endpackage

>>> rtl/core/mvne_norm.sv
`timescale 1ns / 1ps

module mvne_norm import mvne_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    flat_i,
  input  logic [15:0]             thresh_i,
  input  logic [3*ACC_BITS-1:0]   comp_i,
  output logic                    done_o,
  output res_t                    res_o
);

  typedef enum logic [3:0] {
    N_IDLE, N_CHK, N_SQ, N_ADD, N_CMP, N_SHIFT, N_SQRT, N_DIV, N_FIN
  } nstate_e;

  nstate_e              state_q;
  logic [2:0]           sign_q;
  logic [ACC_BITS-1:0]  mg_q [3];
  logic [1:0]           k_q;
  logic                 chk_q;
  logic [59:0]          prod_q;
  logic [61:0]          sum_q;
  logic [31:0]          tt_q;
  logic [63:0]          s_q;
  logic [63:0]          r_q;
  logic [63:0]          bit_q;
  logic [45:0]          d_q;
  logic [45:0]          rem_q [3];
  logic [14:0]          q_q [3];
  logic [3:0]           cnt_q;
  logic                 done_q;
  res_t                 res_q;

  logic signed [ACC_BITS-1:0] comp [3];
  logic [ACC_BITS-1:0]        mag_in [3];
  logic [29:0]                sq_op;
  logic [63:0]                rb;
  logic                       any_hi30, all_lt29, any_hi16, all_zero;

  function automatic logic signed [15:0] to_q14(input logic [14:0] q, input logic neg);
    logic [14:0] c;
    c = (q > 15'd16384) ? 15'd16384 : q;
    to_q14 = neg ? -signed'({1'b0, c}) : signed'({1'b0, c});
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i]   = signed'(comp_i[i*ACC_BITS +: ACC_BITS]);
      mag_in[i] = comp[i][ACC_BITS-1] ? ACC_BITS'(-comp[i]) : ACC_BITS'(comp[i]);
    end
  end

  always_comb begin
    any_hi30 = 1'b0;
    all_lt29 = 1'b1;
    any_hi16 = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_hi30 = any_hi30 | (|mg_q[i][ACC_BITS-1:30]);
      all_lt29 = all_lt29 & ~(|mg_q[i][ACC_BITS-1:29]);
      any_hi16 = any_hi16 | (|mg_q[i][ACC_BITS-1:16]);
      all_zero = all_zero & ~(|mg_q[i]);
    end
  end

  always_comb begin
    case (k_q)
      2'd0:    sq_op = mg_q[0][29:0];
      2'd1:    sq_op = mg_q[1][29:0];
      2'd2:    sq_op = mg_q[2][29:0];
      default: sq_op = 30'(thresh_i);
    endcase
  end

  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < 3; i++) begin
              sign_q[i] <= comp[i][ACC_BITS-1];
              mg_q[i]   <= mag_in[i];
            end
            state_q <= N_CHK;
          end
        end
        N_CHK: begin
          k_q   <= 2'd0;
          sum_q <= '0;
          if (all_zero) begin
            res_q   <= RES_DEFAULT;
            done_q  <= 1'b1;
            state_q <= N_IDLE;
          end else if (flat_i || any_hi16) begin
            state_q <= N_SHIFT;
          end else begin
            chk_q   <= 1'b1;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          prod_q  <= sq_op * sq_op;
          state_q <= N_ADD;
        end
        N_ADD: begin
          if (chk_q && k_q == 2'd3) begin
            tt_q    <= prod_q[31:0];
            state_q <= N_CMP;
          end else if (!chk_q && k_q == 2'd2) begin
            s_q     <= 64'(sum_q + 62'(prod_q));
            r_q     <= '0;
            bit_q   <= 64'd1 << 62;
            state_q <= N_SQRT;
          end else begin
            sum_q   <= sum_q + 62'(prod_q);
            k_q     <= k_q + 2'd1;
            state_q <= N_SQ;
          end
        end
        N_CMP: begin
          if (sum_q <= 62'(tt_q)) begin
            res_q   <= RES_DEFAULT;
            done_q  <= 1'b1;
            state_q <= N_IDLE;
          end else begin
            state_q <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (any_hi30) begin
            for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] >> 1;
          end else if (all_lt29) begin
            for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] << 1;
          end else begin
            chk_q   <= 1'b0;
            k_q     <= 2'd0;
            sum_q   <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQRT: begin
          if (bit_q == 64'd0) begin
            d_q <= {r_q[31:0], 14'd0};
            for (int i = 0; i < 3; i++) begin
              rem_q[i] <= {2'd0, mg_q[i][29:0], 14'd0} + 46'(r_q[31:1]);
              q_q[i]   <= '0;
            end
            cnt_q   <= '0;
            state_q <= N_DIV;
          end else begin
            if (s_q >= rb) begin
              s_q <= s_q - rb;
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (rem_q[i] >= d_q) begin
              rem_q[i] <= rem_q[i] - d_q;
              q_q[i]   <= {q_q[i][13:0], 1'b1};
            end else begin
              q_q[i]   <= {q_q[i][13:0], 1'b0};
            end
          end
          d_q   <= d_q >> 1;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd14) state_q <= N_FIN;
        end
        N_FIN: begin
          res_q.normal_x     <= to_q14(q_q[0], sign_q[0]);
          res_q.normal_y     <= to_q14(q_q[1], sign_q[1]);
          res_q.normal_z     <= to_q14(q_q[2], sign_q[2]);
          res_q.used_default <= 1'b0;
          done_q             <= 1'b1;
          state_q            <= N_IDLE;
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/core/mesh_vertex_normal_engine_top.sv
`timescale 1ns / 1ps
// load: written as accepted; triangle: flat mode overwrites and smooth mode adds
// (single read and write port on the accumulator memory, one shared multiplier)
// read: a default result or a normalized one, set by normalizing shift (one
// bit per cycle), square root and 15-step divider; one item at a time
// reset clears control and output valid and presets the config registers;
// memories hold garbage until written

module mesh_vertex_normal_engine_top import mvne_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int POS_BITS     = POS_BITS_DEF,
  parameter int ACC_BITS     = ACC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // vertex_index, corner_b, corner_c, pos_x, pos_y, pos_z
  input  logic [79:0] s_axis_tdata,
  // cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0] m_axis_tdata,
  // used_default
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int EW = POS_BITS + 1;
  localparam int CW = 2 * EW + 1;
  localparam int WW = ((CW > ACC_BITS) ? CW : ACC_BITS) + 1;
  localparam logic signed [WW-1:0] AMAX =
    signed'({{(WW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}});
  localparam logic signed [WW-1:0] AMIN = ~AMAX;
  localparam longint PMAX = (longint'(1) <<< (POS_BITS-1)) - 1;
  localparam longint PMIN = -PMAX - 1;

  typedef enum logic [2:0] {
    S_IDLE, S_TRI_RD, S_TRI_MUL, S_ACC_RD, S_ACC_WR, S_RD_WAIT, S_RD_NORM, S_OUT
  } state_e;

  state_e                      state_q;
  logic [2:0]                  cnt_q;
  logic [1:0]                  ci_q;
  logic [AW-1:0]               va_q, vb_q, vc_q;
  logic signed [POS_BITS-1:0]  p0_q [3];
  logic signed [POS_BITS-1:0]  p1_q [3];
  logic signed [EW-1:0]        e1_q [3];
  logic signed [EW-1:0]        e2_q [3];
  logic signed [2*EW-1:0]      prod_q;
  logic signed [CW-1:0]        cr_q [3];
  logic signed [ACC_BITS-1:0]  n_q [3];
  res_t                        res_q;
  logic                        m_valid_q;
  logic [47:0]                 m_data_q;
  logic                        m_user_q;
  logic                        flat_q;
  logic [15:0]                 thr_q;

  logic [3*POS_BITS-1:0] pos_mem [VERTEX_COUNT];
  logic [3*ACC_BITS-1:0] acc_mem [VERTEX_COUNT];
  logic [3*POS_BITS-1:0] pos_rd_q;
  logic [3*ACC_BITS-1:0] acc_rd_q;

  cmd_e                       in_cmd;
  logic [9:0]                 in_vi, in_cb, in_cc;
  logic signed [15:0]         in_pos [3];
  logic                       in_acc, a_ok, b_ok, c_ok;
  logic signed [POS_BITS-1:0] pr [3];
  logic signed [ACC_BITS-1:0] ar [3];
  logic signed [EW-1:0]       mul_a, mul_b;
  logic [AW-1:0]              corner;
  logic                       pos_we, pos_re, acc_we, acc_re;
  logic [AW-1:0]              pos_raddr, acc_waddr, acc_raddr;
  logic [3*POS_BITS-1:0]      pos_wdata;
  logic [3*ACC_BITS-1:0]      acc_wdata;
  logic                       norm_start, norm_done;
  res_t                       norm_res;

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [15:0] v);
    longint w;
    w = longint'(v);
    if (w > PMAX) w = PMAX;
    else if (w < PMIN) w = PMIN;
    sat_pos = POS_BITS'(w);
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [CW-1:0] v);
    logic signed [WW-1:0] w;
    w = WW'(v);
    if (w > AMAX) w = AMAX;
    else if (w < AMIN) w = AMIN;
    sat_acc = ACC_BITS'(w);
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a, input logic signed [ACC_BITS-1:0] b);
    logic signed [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      sat_add = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      sat_add = s[ACC_BITS-1:0];
    end
  endfunction

  assign in_cmd    = cmd_e'(s_axis_tuser);
  assign in_vi     = s_axis_tdata[9:0];
  assign in_cb     = s_axis_tdata[19:10];
  assign in_cc     = s_axis_tdata[29:20];
  assign in_pos[0] = signed'(s_axis_tdata[45:30]);
  assign in_pos[1] = signed'(s_axis_tdata[61:46]);
  assign in_pos[2] = signed'(s_axis_tdata[77:62]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign a_ok          = 32'(in_vi) < 32'(VERTEX_COUNT);
  assign b_ok          = 32'(in_cb) < 32'(VERTEX_COUNT);
  assign c_ok          = 32'(in_cc) < 32'(VERTEX_COUNT);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i] = signed'(pos_rd_q[i*POS_BITS +: POS_BITS]);
      ar[i] = signed'(acc_rd_q[i*ACC_BITS +: ACC_BITS]);
      pos_wdata[i*POS_BITS +: POS_BITS] = sat_pos(in_pos[i]);
    end
  end

  always_comb begin
    case (cnt_q)
      3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      3'd5:    begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  always_comb begin
    case (ci_q)
      2'd0:    corner = va_q;
      2'd1:    corner = vb_q;
      default: corner = vc_q;
    endcase
  end

  always_comb begin
    pos_we    = in_acc && in_cmd == CMD_LOAD && a_ok;
    pos_re    = 1'b0;
    pos_raddr = AW'(in_vi);
    acc_we    = pos_we;
    acc_waddr = AW'(in_vi);
    acc_wdata = '0;
    acc_re    = 1'b0;
    acc_raddr = AW'(in_vi);
    case (state_q)
      S_IDLE: begin
        pos_re = in_acc && in_cmd == CMD_TRI;
        acc_re = in_acc && in_cmd == CMD_READ && a_ok;
      end
      S_TRI_RD: begin
        pos_re    = (cnt_q != 3'd2);
        pos_raddr = (cnt_q == 3'd0) ? vb_q : vc_q;
      end
      S_ACC_RD: begin
        acc_waddr = corner;
        acc_raddr = corner;
        acc_we    = flat_q;
        acc_re    = !flat_q;
        acc_wdata = {n_q[2], n_q[1], n_q[0]};
      end
      S_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = corner;
        acc_wdata = {sat_add(ar[2], n_q[2]), sat_add(ar[1], n_q[1]), sat_add(ar[0], n_q[0])};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[AW'(in_vi)] <= pos_wdata;
    if (pos_re) pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (acc_re) acc_rd_q <= acc_mem[acc_raddr];
  end

  assign norm_start = (state_q == S_RD_WAIT);

  mvne_norm #(
    .ACC_BITS (ACC_BITS)
  ) u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (norm_start),
    .flat_i   (flat_q),
    .thresh_i (thr_q),
    .comp_i   (acc_rd_q),
    .done_o   (norm_done),
    .res_o    (norm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ci_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready && state_q != S_OUT) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_cmd)
              CMD_TRI: begin
                if (a_ok && b_ok && c_ok) begin
                  va_q    <= AW'(in_vi);
                  vb_q    <= AW'(in_cb);
                  vc_q    <= AW'(in_cc);
                  cnt_q   <= '0;
                  state_q <= S_TRI_RD;
                end
              end
              CMD_READ: begin
                if (a_ok) begin
                  state_q <= S_RD_WAIT;
                end else begin
                  res_q   <= RES_DEFAULT;
                  state_q <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_TRI_RD: begin
          cnt_q <= cnt_q + 3'd1;
          case (cnt_q)
            3'd0: p0_q <= pr;
            3'd1: p1_q <= pr;
            default: begin
              for (int i = 0; i < 3; i++) begin
                e1_q[i] <= EW'(p1_q[i]) - EW'(p0_q[i]);
                e2_q[i] <= EW'(pr[i]) - EW'(p0_q[i]);
              end
              cnt_q   <= '0;
              state_q <= S_TRI_MUL;
            end
          endcase
        end
        S_TRI_MUL: begin
          cnt_q  <= cnt_q + 3'd1;
          prod_q <= mul_a * mul_b;
          case (cnt_q)
            3'd1: cr_q[0] <= CW'(prod_q);
            3'd2: cr_q[0] <= cr_q[0] - CW'(prod_q);
            3'd3: cr_q[1] <= CW'(prod_q);
            3'd4: cr_q[1] <= cr_q[1] - CW'(prod_q);
            3'd5: cr_q[2] <= CW'(prod_q);
            3'd6: cr_q[2] <= cr_q[2] - CW'(prod_q);
            3'd7: begin
              for (int i = 0; i < 3; i++) n_q[i] <= sat_acc(cr_q[i]);
              ci_q    <= '0;
              state_q <= S_ACC_RD;
            end
            default: ;
          endcase
        end
        S_ACC_RD: begin
          if (!flat_q) begin
            state_q <= S_ACC_WR;
          end else if (ci_q == 2'd2) begin
            state_q <= S_IDLE;
          end else begin
            ci_q <= ci_q + 2'd1;
          end
        end
        S_ACC_WR: begin
          if (ci_q == 2'd2) begin
            state_q <= S_IDLE;
          end else begin
            ci_q    <= ci_q + 2'd1;
            state_q <= S_ACC_RD;
          end
        end
        S_RD_WAIT: state_q <= S_RD_NORM;
        S_RD_NORM: begin
          if (norm_done) begin
            res_q   <= norm_res;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {res_q.normal_z, res_q.normal_y, res_q.normal_x};
            m_user_q  <= res_q.used_default;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_q <= 1'b0;
      thr_q  <= THRESH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_FLAT:   flat_q <= pwdata[0];
        REG_THRESH: thr_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FLAT: prdata = {31'd0, flat_q};
      default:  prdata = {16'd0, thr_q};
    endcase
  end

  assign pready = 1'b1;

  a_default_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == {ONE_Q14, 32'd0}))
    else $error("default item with wrong normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384 &&
                       $signed(m_axis_tdata[31:16]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[31:16]) >= -16'sd16384 &&
                       $signed(m_axis_tdata[47:32]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[47:32]) >= -16'sd16384))
    else $error("normal component out of range");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_cmd == CMD_READ) |=> !s_axis_tready)
    else $error("read item did not block input");

  a_norm_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> state_q == S_RD_NORM)
    else $error("normalizer finished outside a read");

endmodule
